@@ design/rolling_vwap_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the rolling VWAP block
// Shared wrappers so every concurrent check is written the same way.
// ----------------------------------------------------------------------------
`ifndef ROLLING_VWAP_ASSERT_SVH
`define ROLLING_VWAP_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define VWAP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Check a property on every rising edge while reset is held.
`define VWAP_ASSERT_IN_RESET(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) !rst_n |-> prop) else $error(msg);

`endif

@@ design/vwap_pkg.sv @@
// ----------------------------------------------------------------------------
// vwap_pkg
// Widths, reset values, register codes, queue entry and state types shared by
// the rolling VWAP modules.
// ----------------------------------------------------------------------------
package vwap_pkg;

	// Field widths.
	localparam int PRICE_W    = 32;
	localparam int VOL_IN_W   = 24;
	localparam int VOL_W      = 23;
	localparam int PV_W       = 55;
	localparam int TOT_VOL_W  = 31;
	localparam int TOT_PV_W   = 63;
	localparam int AVG_W      = 32;
	localparam int SUM_W      = PRICE_W + 2;

	// Configuration port.
	localparam int WLEN_W     = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 31;

	localparam logic [WLEN_W-1:0]    WLEN_RESET    = WLEN_W'(20);
	localparam logic [TOT_VOL_W-1:0] MIN_VOL_RESET = TOT_VOL_W'(1);

	// Default ring depth.
	localparam int DEF_MAX_WINDOW = 256;

	// Depth of the queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;

	// Register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_LENGTH    = 1'b0,
		CFG_MIN_TOTAL_VOLUME = 1'b1
	} cfg_index_t;

	// One prepared bar: clamped volume and typical price times volume.
	typedef struct packed {
		logic [VOL_W-1:0] vol;
		logic [PV_W-1:0]  pv;
	} entry_t;

	// Front sequencer.
	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_MUL,
		F_PUSH
	} front_state_t;

	// Back sequencer.
	typedef enum logic [2:0] {
		B_IDLE,
		B_SUB,
		B_ADD,
		B_CHK,
		B_DIV,
		B_DONE
	} back_state_t;

endpackage

@@ design/vwap_bar_if.sv @@
// ----------------------------------------------------------------------------
// vwap_bar_if
// Input channel: one market bar per item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vwap_bar_if;
	logic                                valid;
	logic                                ready;
	logic [vwap_pkg::PRICE_W-1:0]        bar_high;
	logic [vwap_pkg::PRICE_W-1:0]        bar_low;
	logic [vwap_pkg::PRICE_W-1:0]        bar_close;
	logic signed [vwap_pkg::VOL_IN_W-1:0] bar_volume;

	modport source (
		output valid, bar_high, bar_low, bar_close, bar_volume,
		input  ready
	);

	modport sink (
		input  valid, bar_high, bar_low, bar_close, bar_volume,
		output ready
	);
endinterface

@@ design/vwap_result_if.sv @@
// ----------------------------------------------------------------------------
// vwap_result_if
// Output channel: one VWAP result per item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vwap_result_if;
	logic                           valid;
	logic                           ready;
	logic [vwap_pkg::AVG_W-1:0]     average_price;
	logic [vwap_pkg::TOT_VOL_W-1:0] window_volume;
	logic [vwap_pkg::TOT_PV_W-1:0]  window_price_volume;

	modport source (
		output valid, average_price, window_volume, window_price_volume,
		input  ready
	);

	modport sink (
		input  valid, average_price, window_volume, window_price_volume,
		output ready
	);
endinterface

@@ design/vwap_front.sv @@
// ----------------------------------------------------------------------------
// vwap_front
// Accepts bars, clamps the volume, forms the typical price with a reciprocal
// multiplication by one third and multiplies it by the volume for the back part.
// ----------------------------------------------------------------------------
module vwap_front (
	input  logic             clk,
	input  logic             arst_n,
	vwap_bar_if.sink         bar,
	output logic             push,
	output vwap_pkg::entry_t push_entry,
	input  logic             q_full
);

	// Reciprocal of three, ceil(2^36 / 3), split at bit 18 so each product stays narrow.
	// It gives the exact floor quotient for every sum below 2^35.
	localparam int                   RCP_SPLIT = 18;
	localparam int                   ACC_W     = vwap_pkg::SUM_W + RCP_SPLIT;
	localparam logic [RCP_SPLIT-1:0] RCP_LO    = 18'h15556;
	localparam logic [16:0]          RCP_HI    = 17'h15555;

	vwap_pkg::front_state_t state_q, state_d;

	logic [vwap_pkg::SUM_W-1:0] sum_q;
	logic [ACC_W-1:0]           acc_q;
	logic                       phase_q;
	logic [vwap_pkg::VOL_W-1:0] vol_q;
	logic [vwap_pkg::PV_W-1:0]  pv_q;

	logic [vwap_pkg::SUM_W-1:0] sum_c;
	logic [vwap_pkg::VOL_W-1:0] vol_c;

	// Sum of the three prices and the clamped volume of the offered bar.
	assign sum_c = vwap_pkg::SUM_W'(bar.bar_high) + vwap_pkg::SUM_W'(bar.bar_low)
		+ vwap_pkg::SUM_W'(bar.bar_close);
	assign vol_c = (bar.bar_volume[vwap_pkg::VOL_IN_W-1] || (bar.bar_volume == '0))
		? vwap_pkg::VOL_W'(1) : bar.bar_volume[vwap_pkg::VOL_W-1:0];

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vwap_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshakes.
	always_comb begin
		state_d   = state_q;
		bar.ready = 1'b0;
		push      = 1'b0;
		unique case (state_q)
			vwap_pkg::F_IDLE: begin
				bar.ready = 1'b1;
				if (bar.valid) begin
					state_d = vwap_pkg::F_DIV;
				end
			end
			vwap_pkg::F_DIV: begin
				if (phase_q) begin
					state_d = vwap_pkg::F_MUL;
				end
			end
			vwap_pkg::F_MUL: begin
				state_d = vwap_pkg::F_PUSH;
			end
			vwap_pkg::F_PUSH: begin
				if (!q_full) begin
					push    = 1'b1;
					state_d = vwap_pkg::F_IDLE;
				end
			end
			default: begin
				state_d = vwap_pkg::F_IDLE;
			end
		endcase
	end

	// Datapath: the low half of the reciprocal first, then the high half plus the
	// carried upper bits of the first product, so the quotient sits above bit 18.
	always_ff @(posedge clk) begin
		case (state_q)
			vwap_pkg::F_IDLE: begin
				if (bar.valid) begin
					sum_q   <= sum_c;
					vol_q   <= vol_c;
					phase_q <= 1'b0;
				end
			end
			vwap_pkg::F_DIV: begin
				if (!phase_q) begin
					acc_q <= ACC_W'(sum_q) * ACC_W'(RCP_LO);
				end else begin
					acc_q <= ACC_W'(sum_q) * ACC_W'(RCP_HI) + (acc_q >> RCP_SPLIT);
				end
				phase_q <= 1'b1;
			end
			vwap_pkg::F_MUL: begin
				pv_q <= vwap_pkg::PV_W'(acc_q[RCP_SPLIT +: vwap_pkg::PRICE_W])
					* vwap_pkg::PV_W'(vol_q);
			end
			default: begin
			end
		endcase
	end

	assign push_entry.vol = vol_q;
	assign push_entry.pv  = pv_q;

endmodule

@@ design/vwap_queue.sv @@
// ----------------------------------------------------------------------------
// vwap_queue
// Short first-in first-out queue of prepared bars between front and back.
// ----------------------------------------------------------------------------
module vwap_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  vwap_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output vwap_pkg::entry_t pop_entry,
	output logic             empty
);

	localparam int PTR_W = (vwap_pkg::QUEUE_DEPTH > 1) ? $clog2(vwap_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(vwap_pkg::QUEUE_DEPTH + 1);

	vwap_pkg::entry_t slot_q [vwap_pkg::QUEUE_DEPTH];

	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(vwap_pkg::QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign pop_entry = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(vwap_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(vwap_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

@@ design/vwap_back.sv @@
// ----------------------------------------------------------------------------
// vwap_back
// Keeps the window rings and running totals, divides the price-volume sum by
// the volume sum one quotient bit a cycle and holds the result for the sink.
// ----------------------------------------------------------------------------
module vwap_back #(
	parameter int MAX_WINDOW = vwap_pkg::DEF_MAX_WINDOW
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  vwap_pkg::entry_t                   pop_entry,
	input  logic                               q_empty,
	output logic                               pop,
	input  logic                               clear,
	input  logic [vwap_pkg::WLEN_W-1:0]        window_length,
	input  logic [vwap_pkg::TOT_VOL_W-1:0]     min_total_volume,
	vwap_result_if.source                      result
);

	localparam int AW    = $clog2(MAX_WINDOW);
	localparam int FW    = $clog2(MAX_WINDOW + 1);
	localparam int CW    = (FW > vwap_pkg::WLEN_W) ? FW : vwap_pkg::WLEN_W;
	localparam int OW    = FW + 1;
	localparam int HI_W  = vwap_pkg::TOT_PV_W - vwap_pkg::AVG_W;
	localparam int DCNT_W = $clog2(vwap_pkg::AVG_W + 1);

	vwap_pkg::back_state_t state_q, state_d;

	// Window rings, one entry per bar.
	vwap_pkg::entry_t ring_mem [MAX_WINDOW];

	vwap_pkg::entry_t                 cur_q;
	vwap_pkg::entry_t                 rd_q;
	logic [AW-1:0]                    head_q;
	logic [FW-1:0]                    fill_q;
	logic [vwap_pkg::TOT_VOL_W-1:0]   tot_vol_q;
	logic [vwap_pkg::TOT_PV_W-1:0]    tot_pv_q;
	logic [HI_W-1:0]                  rem_q;
	logic [vwap_pkg::AVG_W-1:0]       quo_q;
	logic [DCNT_W-1:0]                dcnt_q;
	logic                             out_valid_q;
	logic [vwap_pkg::AVG_W-1:0]       avg_out_q;
	logic [vwap_pkg::TOT_VOL_W-1:0]   vol_out_q;
	logic [vwap_pkg::TOT_PV_W-1:0]    pv_out_q;

	logic [CW-1:0]  wl_ext;
	logic [CW-1:0]  eff_ext;
	logic [FW-1:0]  eff_win;
	logic [OW-1:0]  old_sum;
	logic [OW-1:0]  old_fix;
	logic [AW-1:0]  old_addr;
	logic           full_win;
	logic           zero_avg;
	logic           too_wide;
	logic [HI_W:0]  div_shift;
	logic           div_ge;
	logic           load_out;

	// Window length in force: zero counts as one, the ring depth caps it.
	assign wl_ext = CW'(window_length);
	always_comb begin
		if (wl_ext == '0) begin
			eff_ext = CW'(1);
		end else if (wl_ext > CW'(MAX_WINDOW)) begin
			eff_ext = CW'(MAX_WINDOW);
		end else begin
			eff_ext = wl_ext;
		end
	end
	assign eff_win = FW'(eff_ext);

	// Slot of the oldest bar in the window, modulo the ring depth.
	assign old_sum  = OW'(head_q) + OW'(MAX_WINDOW) - OW'(fill_q);
	assign old_fix  = (old_sum >= OW'(MAX_WINDOW)) ? old_sum - OW'(MAX_WINDOW) : old_sum;
	assign old_addr = old_fix[AW-1:0];
	assign full_win = (fill_q >= eff_win);

	// Result classes that need no division.
	assign zero_avg = (tot_vol_q < min_total_volume) || (tot_vol_q == '0);
	assign too_wide = (tot_pv_q[vwap_pkg::TOT_PV_W-1:vwap_pkg::AVG_W] >= tot_vol_q);

	// One restoring division step.
	assign div_shift = {rem_q, quo_q[vwap_pkg::AVG_W-1]};
	assign div_ge    = (div_shift >= (HI_W + 1)'(tot_vol_q));

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vwap_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, queue pop and output load.
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			vwap_pkg::B_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = vwap_pkg::B_SUB;
				end
			end
			vwap_pkg::B_SUB: begin
				state_d = vwap_pkg::B_ADD;
			end
			vwap_pkg::B_ADD: begin
				state_d = vwap_pkg::B_CHK;
			end
			vwap_pkg::B_CHK: begin
				if (zero_avg || too_wide) begin
					state_d = vwap_pkg::B_DONE;
				end else begin
					state_d = vwap_pkg::B_DIV;
				end
			end
			vwap_pkg::B_DIV: begin
				if (dcnt_q == DCNT_W'(1)) begin
					state_d = vwap_pkg::B_DONE;
				end
			end
			vwap_pkg::B_DONE: begin
				if (!out_valid_q || result.ready) begin
					load_out = 1'b1;
					state_d  = vwap_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = vwap_pkg::B_IDLE;
			end
		endcase
	end

	// Ring position, fill and totals; a window length write empties the window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			fill_q    <= '0;
			tot_vol_q <= '0;
			tot_pv_q  <= '0;
		end else if (clear) begin
			fill_q    <= '0;
			tot_vol_q <= '0;
			tot_pv_q  <= '0;
		end else begin
			case (state_q)
				vwap_pkg::B_SUB: begin
					if (full_win) begin
						tot_vol_q <= tot_vol_q - vwap_pkg::TOT_VOL_W'(rd_q.vol);
						tot_pv_q  <= tot_pv_q - vwap_pkg::TOT_PV_W'(rd_q.pv);
						fill_q    <= eff_win;
					end else begin
						fill_q <= fill_q + FW'(1);
					end
				end
				vwap_pkg::B_ADD: begin
					tot_vol_q <= tot_vol_q + vwap_pkg::TOT_VOL_W'(cur_q.vol);
					tot_pv_q  <= tot_pv_q + vwap_pkg::TOT_PV_W'(cur_q.pv);
					head_q    <= (head_q == AW'(MAX_WINDOW - 1)) ? '0 : head_q + AW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Ring memory: registered read of the oldest slot, write of the new bar.
	always_ff @(posedge clk) begin
		rd_q <= ring_mem[old_addr];
		if (state_q == vwap_pkg::B_ADD) begin
			ring_mem[head_q] <= cur_q;
		end
	end

	// Current bar and divider datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			vwap_pkg::B_IDLE: begin
				if (!q_empty) begin
					cur_q <= pop_entry;
				end
			end
			vwap_pkg::B_CHK: begin
				if (zero_avg) begin
					quo_q <= '0;
				end else if (too_wide) begin
					quo_q <= '1;
				end else begin
					rem_q  <= tot_pv_q[vwap_pkg::TOT_PV_W-1:vwap_pkg::AVG_W];
					quo_q  <= tot_pv_q[vwap_pkg::AVG_W-1:0];
					dcnt_q <= DCNT_W'(vwap_pkg::AVG_W);
				end
			end
			vwap_pkg::B_DIV: begin
				rem_q  <= div_ge ? HI_W'(div_shift - (HI_W + 1)'(tot_vol_q))
					: div_shift[HI_W-1:0];
				quo_q  <= {quo_q[vwap_pkg::AVG_W-2:0], div_ge};
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_out) begin
			avg_out_q <= quo_q;
			vol_out_q <= tot_vol_q;
			pv_out_q  <= tot_pv_q;
		end
	end

	assign result.valid               = out_valid_q;
	assign result.average_price       = avg_out_q;
	assign result.window_volume       = vol_out_q;
	assign result.window_price_volume = pv_out_q;

endmodule

@@ design/rolling_vwap.sv @@
// ----------------------------------------------------------------------------
// rolling_vwap
// Rolling volume weighted average price over the most recent bars.
// ----------------------------------------------------------------------------
// Usage:
// The bar channel takes one bar per item (high, low, close, volume). The result
// channel gives one item per bar: the average price, or zero when the window
// volume is below min_total_volume, plus both window sums.
// The front part takes a bar, forms the low and then the high half of a
// reciprocal multiplication by one third, does the volume multiply and hands
// the entry to the queue; it takes the next bar only after that hand-over. The
// back part pops an entry, drops the oldest bar of a full window, adds the new
// one, checks the result class and runs a one-bit-per-cycle restoring divider,
// which it skips when the average is zero or saturated. The back part can still
// be working on earlier bars while the front takes new ones.
// A two-entry queue sits between front and back, and the result sits in an
// output register, so a stalled receiver holds one result while the next bars
// are still taken and worked on until the queue fills.
// Reset clears the window, the ring position and both registers to their
// defaults (window of 20 bars, minimum volume of one LSB). The ring memory needs
// no clearing pass. Writing window_length empties the window.
// ----------------------------------------------------------------------------
module rolling_vwap #(
	parameter int MAX_WINDOW = vwap_pkg::DEF_MAX_WINDOW
) (
	input  logic                               clk,
	input  logic                               arst_n,
	vwap_bar_if.sink                           bar,
	vwap_result_if.source                      result,
	input  logic                               cfg_we,
	input  logic [vwap_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vwap_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [vwap_pkg::WLEN_W-1:0]    window_length_q;
	logic [vwap_pkg::TOT_VOL_W-1:0] min_total_volume_q;
	logic                           clear;

	logic             push;
	vwap_pkg::entry_t push_entry;
	logic             q_full;
	logic             pop;
	vwap_pkg::entry_t pop_entry;
	logic             q_empty;

	assign clear = cfg_we && (cfg_index == vwap_pkg::CFG_WINDOW_LENGTH);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q    <= vwap_pkg::WLEN_RESET;
			min_total_volume_q <= vwap_pkg::MIN_VOL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vwap_pkg::CFG_WINDOW_LENGTH: begin
					window_length_q <= cfg_data[vwap_pkg::WLEN_W-1:0];
				end
				vwap_pkg::CFG_MIN_TOTAL_VOLUME: begin
					min_total_volume_q <= cfg_data[vwap_pkg::TOT_VOL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Front: accepts and prepares bars.
	vwap_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.bar        (bar),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	// Queue between the two parts.
	vwap_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (q_empty)
	);

	// Back: window sums, division and result register.
	vwap_back #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.pop_entry        (pop_entry),
		.q_empty          (q_empty),
		.pop              (pop),
		.clear            (clear),
		.window_length    (window_length_q),
		.min_total_volume (min_total_volume_q),
		.result           (result)
	);

endmodule

@@ design/vwap_checker.sv @@
// ----------------------------------------------------------------------------
// vwap_checker
// Port-level checks of the rolling VWAP block, bound to the top level.
// ----------------------------------------------------------------------------
`include "rolling_vwap_assert.svh"

module vwap_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              bar_valid,
	input logic                              bar_ready,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic [vwap_pkg::AVG_W-1:0]        average_price,
	input logic [vwap_pkg::TOT_VOL_W-1:0]    window_volume,
	input logic [vwap_pkg::TOT_PV_W-1:0]     window_price_volume
);

	// A result waiting on the sink stays offered.
	`VWAP_ASSERT(a_res_hold, clk, arst_n, res_valid && !res_ready |=> res_valid, "result item dropped while stalled")

	// A result waiting on the sink keeps its payload.
	`VWAP_ASSERT(a_res_stable, clk, arst_n, res_valid && !res_ready |=> $stable(average_price) && $stable(window_volume) && $stable(window_price_volume), "result item changed while stalled")

	// An empty window volume never yields a nonzero average.
	`VWAP_ASSERT(a_zero_vol, clk, arst_n, res_valid && (window_volume == '0) |-> average_price == '0, "nonzero average over zero volume")

	// The front is busy dividing right after it takes a bar.
	`VWAP_ASSERT(a_busy_after_accept, clk, arst_n, bar_valid && bar_ready |=> !bar_ready, "bar taken while the previous one is in work")

	// No result is offered while reset is held.
	`VWAP_ASSERT_IN_RESET(a_reset_quiet, clk, arst_n, !res_valid, "result offered during reset")

endmodule

bind rolling_vwap vwap_checker u_vwap_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.bar_valid           (bar.valid),
	.bar_ready           (bar.ready),
	.res_valid           (result.valid),
	.res_ready           (result.ready),
	.average_price       (result.average_price),
	.window_volume       (result.window_volume),
	.window_price_volume (result.window_price_volume)
);

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: rolling VWAP testbench
// Drives market bars into rolling_vwap and checks every result item against
// a predictor that keeps its own rings and window sums. A short directed
// part covers the extremes of the fields and the window rules. Random phases
// follow, one per register setting, each under one of three idling patterns.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vwap_pkg::*;

	localparam int RING_DEPTH  = DEF_MAX_WINDOW;
	localparam int POS_W       = $clog2(RING_DEPTH);
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_TAIL  = 100;

	// Idling patterns of the two channels.
	typedef enum int {
		SEND_LIGHT_RECV_HEAVY,
		SEND_HEAVY_RECV_LIGHT,
		NO_IDLE
	} idle_mode_e;

	typedef struct packed {
		logic [PRICE_W-1:0]         price_high;
		logic [PRICE_W-1:0]         price_low;
		logic [PRICE_W-1:0]         price_close;
		logic signed [VOL_IN_W-1:0] volume;
	} bar_t;

	typedef struct packed {
		logic [AVG_W-1:0]     average_price;
		logic [TOT_VOL_W-1:0] window_volume;
		logic [TOT_PV_W-1:0]  window_price_volume;
	} vwap_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_index_t            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	vwap_bar_if    bar_ch ();
	vwap_result_if result_ch ();

	rolling_vwap u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bar       (bar_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Bars waiting to be sent and VWAP items waiting to come back.
	bar_t  pending_bars[$];
	vwap_t expected_vwaps[$];

	int   send_idle_pct;
	int   recv_stall_pct;
	int   error_count;
	int   cycle_count;
	logic bar_taken;

	// Predictor state: the window rings, their position and the running sums.
	logic [VOL_W-1:0]     vol_hist[RING_DEPTH];
	logic [PV_W-1:0]      pv_hist[RING_DEPTH];
	logic [POS_W-1:0]     hist_pos;
	logic [WLEN_W-1:0]    hist_count;
	logic [TOT_VOL_W-1:0] sum_vol;
	logic [TOT_PV_W-1:0]  sum_pv;
	logic [WLEN_W-1:0]    window_setting;
	logic [TOT_VOL_W-1:0] min_vol_setting;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Moves one bar into the window and computes the VWAP item it yields.
	task automatic predict_vwap(input bar_t b);
		logic [VOL_W-1:0]     vol;
		logic [SUM_W-1:0]     price_sum;
		logic [PRICE_W-1:0]   typical;
		logic [PV_W-1:0]      pv;
		logic [WLEN_W-1:0]    span;
		logic [POS_W-1:0]     oldest;
		logic [TOT_PV_W-1:0]  quotient;
		vwap_t                r;

		// A volume at or below zero counts as one LSB.
		if (b.volume <= 0)
			vol = VOL_W'(1);
		else
			vol = b.volume[VOL_W-1:0];

		price_sum = SUM_W'(b.price_high) + SUM_W'(b.price_low) + SUM_W'(b.price_close);
		typical = PRICE_W'(price_sum / 3);
		pv = PV_W'(typical) * PV_W'(vol);

		// Zero means one bar; anything past the ring depth is the full ring.
		if (window_setting == '0)
			span = WLEN_W'(1);
		else if (window_setting > WLEN_W'(RING_DEPTH))
			span = WLEN_W'(RING_DEPTH);
		else
			span = window_setting;

		// A full window drops its oldest bar first.
		if (hist_count >= span) begin
			oldest = POS_W'(hist_pos - POS_W'(hist_count));
			sum_vol = sum_vol - TOT_VOL_W'(vol_hist[oldest]);
			sum_pv = sum_pv - TOT_PV_W'(pv_hist[oldest]);
			hist_count = span;
		end else begin
			hist_count = hist_count + 1'b1;
		end

		vol_hist[hist_pos] = vol;
		pv_hist[hist_pos] = pv;
		hist_pos = hist_pos + 1'b1;
		sum_vol = sum_vol + TOT_VOL_W'(vol);
		sum_pv = sum_pv + TOT_PV_W'(pv);

		if (sum_vol < min_vol_setting || sum_vol == '0) begin
			r.average_price = '0;
		end else begin
			quotient = sum_pv / TOT_PV_W'(sum_vol);
			if (quotient > TOT_PV_W'({AVG_W{1'b1}}))
				r.average_price = '1;
			else
				r.average_price = AVG_W'(quotient);
		end
		r.window_volume = sum_vol;
		r.window_price_volume = sum_pv;
		expected_vwaps.push_back(r);
	endtask

	// Monitor: checks result items, tracks register writes and accepted bars.
	always @(posedge clk) begin : vwap_monitor
		vwap_t want;
		bar_t  seen;

		bar_taken <= arst_n && bar_ch.valid && bar_ch.ready;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_vwaps.size() == 0) begin
					$error("result item arrived with no bar waiting for it");
					error_count++;
				end else begin
					want = expected_vwaps.pop_front();
					if (result_ch.average_price !== want.average_price) begin
						$error("average_price: expected %h, actual %h",
							want.average_price, result_ch.average_price);
						error_count++;
					end
					if (result_ch.window_volume !== want.window_volume) begin
						$error("window_volume: expected %h, actual %h",
							want.window_volume, result_ch.window_volume);
						error_count++;
					end
					if (result_ch.window_price_volume !== want.window_price_volume) begin
						$error("window_price_volume: expected %h, actual %h",
							want.window_price_volume, result_ch.window_price_volume);
						error_count++;
					end
				end
			end

			// A window length write empties the window but keeps the ring position.
			if (cfg_we) begin
				case (cfg_index)
					CFG_WINDOW_LENGTH: begin
						window_setting = cfg_data[WLEN_W-1:0];
						hist_count = '0;
						sum_vol = '0;
						sum_pv = '0;
					end
					CFG_MIN_TOTAL_VOLUME: begin
						min_vol_setting = cfg_data[TOT_VOL_W-1:0];
					end
					default: begin
					end
				endcase
			end

			if (bar_ch.valid && bar_ch.ready) begin
				seen.price_high = bar_ch.bar_high;
				seen.price_low = bar_ch.bar_low;
				seen.price_close = bar_ch.bar_close;
				seen.volume = bar_ch.bar_volume;
				predict_vwap(seen);
			end
		end
	end

	// Driver: offers queued bars and toggles the receiver's ready.
	always @(negedge clk) begin : bar_driver
		bar_t next_bar;

		if (!arst_n) begin
			bar_ch.valid <= 1'b0;
		end else if (!bar_ch.valid || bar_taken) begin
			if (pending_bars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_bar = pending_bars.pop_front();
				bar_ch.bar_high <= next_bar.price_high;
				bar_ch.bar_low <= next_bar.price_low;
				bar_ch.bar_close <= next_bar.price_close;
				bar_ch.bar_volume <= next_bar.volume;
				bar_ch.valid <= 1'b1;
			end else begin
				bar_ch.valid <= 1'b0;
			end
		end
		result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Waits until no bar is queued or offered and every VWAP item has come back.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_bars.size() != 0 || bar_ch.valid || expected_vwaps.size() != 0);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_bar(input logic [PRICE_W-1:0] h, input logic [PRICE_W-1:0] l,
			input logic [PRICE_W-1:0] c, input logic [VOL_IN_W-1:0] v);
		bar_t b;

		b.price_high = h;
		b.price_low = l;
		b.price_close = c;
		b.volume = v;
		pending_bars.push_back(b);
	endtask

	// Random bar: mostly prices around one level, with full-range and extreme cases.
	function automatic bar_t random_bar();
		bar_t             b;
		logic [PRICE_W-1:0] level;

		case ($urandom_range(7))
			0, 1: begin
				b.price_high = $urandom;
				b.price_low = $urandom;
				b.price_close = $urandom;
			end
			2: begin
				b.price_high = $urandom_range(1) ? '1 : '0;
				b.price_low = $urandom_range(1) ? '1 : '0;
				b.price_close = $urandom_range(1) ? '1 : '0;
			end
			default: begin
				level = $urandom;
				b.price_high = level + PRICE_W'($urandom_range(4095));
				b.price_low = level - PRICE_W'($urandom_range(4095));
				b.price_close = level + PRICE_W'($urandom_range(2047)) - PRICE_W'(1024);
			end
		endcase

		case ($urandom_range(9))
			0: b.volume = '0;
			1: b.volume = {1'b1, VOL_W'($urandom)};
			2: b.volume = {1'b0, {VOL_W{1'b1}}};
			3, 4: b.volume = VOL_IN_W'($urandom_range(1, 255));
			5, 6: b.volume = VOL_IN_W'($urandom_range(256, 65535));
			default: b.volume = VOL_IN_W'($urandom_range(1, 24'h7FFFFF));
		endcase
		return b;
	endfunction

	// One setting of the registers and idling, then a batch of random bars.
	task automatic run_phase(input bit set_window, input logic [WLEN_W-1:0] window,
			input bit set_min, input logic [TOT_VOL_W-1:0] min_vol, input int bars,
			input idle_mode_e mode);
		wait_drained();
		case (mode)
			SEND_LIGHT_RECV_HEAVY: begin
				send_idle_pct = 18;
				recv_stall_pct = 58;
			end
			SEND_HEAVY_RECV_LIGHT: begin
				send_idle_pct = 58;
				recv_stall_pct = 18;
			end
			default: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
		endcase
		if (set_window)
			write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(window));
		if (set_min)
			write_reg(CFG_MIN_TOTAL_VOLUME, CFG_DATA_W'(min_vol));
		repeat (bars)
			pending_bars.push_back(random_bar());
	endtask

	// Stimulus.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_WINDOW_LENGTH;
		cfg_data = '0;
		bar_ch.valid = 1'b0;
		bar_ch.bar_high = '0;
		bar_ch.bar_low = '0;
		bar_ch.bar_close = '0;
		bar_ch.bar_volume = '0;
		result_ch.ready = 1'b0;
		bar_taken = 1'b0;
		error_count = 0;
		cycle_count = 0;
		send_idle_pct = 18;
		recv_stall_pct = 58;

		hist_pos = '0;
		hist_count = '0;
		sum_vol = '0;
		sum_pv = '0;
		window_setting = WLEN_RESET;
		min_vol_setting = MIN_VOL_RESET;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: zero, negative and extreme volumes, extreme prices.
		push_bar('0, '0, '0, 24'h000000);
		push_bar('1, '1, '1, 24'h7FFFFF);
		push_bar('1, '0, '0, 24'hFFFFFF);
		push_bar(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 24'h800000);
		push_bar(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 24'h000001);
		push_bar(32'h0000_0002, '0, '0, 24'h000100);
		push_bar(32'h1234_5678, '0, 32'hFEDC_BA98, 24'h7FFFFF);
		push_bar(32'hAAAA_AAAA, 32'h5555_5555, '1, 24'h555555);

		// A window length of zero acts as a single bar.
		run_phase(1'b1, '0, 1'b0, '0, 0, SEND_LIGHT_RECV_HEAVY);
		push_bar(32'h0010_0000, 32'h000F_0000, 32'h000F_8000, 24'h000200);
		push_bar(32'h0020_0000, 32'h001F_0000, 32'h001F_8000, 24'h000400);
		push_bar('1, '1, '1, 24'h000001);

		// Two-bar window that rolls over, with a threshold nothing reaches.
		run_phase(1'b1, WLEN_W'(2), 1'b1, '1, 0, SEND_LIGHT_RECV_HEAVY);
		push_bar(32'h0050_0000, 32'h0040_0000, 32'h0048_0000, 24'h001000);
		push_bar(32'h0051_0000, 32'h0041_0000, 32'h0049_0000, 24'h7FFFFF);
		push_bar(32'h0052_0000, 32'h0042_0000, 32'h004A_0000, 24'hFFFF00);
		push_bar('1, '1, '1, 24'h7FFFFF);

		// Threshold of zero alone: the window keeps its bars.
		run_phase(1'b0, '0, 1'b1, '0, 0, SEND_LIGHT_RECV_HEAVY);
		push_bar(32'h0100_0000, 32'h00F0_0000, 32'h00F8_0000, 24'h000080);
		push_bar('0, '0, '0, 24'h000080);
		push_bar(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'h000000);

		// Random phases.
		run_phase(1'b1, WLEN_W'(5), 1'b1, TOT_VOL_W'(1), 150, SEND_LIGHT_RECV_HEAVY);
		run_phase(1'b1, WLEN_W'(1), 1'b1, '0, 100, SEND_LIGHT_RECV_HEAVY);
		run_phase(1'b1, WLEN_W'(256), 1'b0, '0, 400, SEND_HEAVY_RECV_LIGHT);
		run_phase(1'b1, '1, 1'b1, TOT_VOL_W'(32'h1800_0000), 300, SEND_HEAVY_RECV_LIGHT);
		run_phase(1'b1, '0, 1'b1, '1, 100, NO_IDLE);
		run_phase(1'b1, WLEN_W'(17), 1'b1, TOT_VOL_W'(32'h0200_0000), 200, NO_IDLE);
		run_phase(1'b0, '0, 1'b1, TOT_VOL_W'(1), 150, NO_IDLE);
		run_phase(1'b1, WLEN_W'(3), 1'b1, TOT_VOL_W'(32'h0040_0000), 350, NO_IDLE);

		// Let the last items come back and watch for strays.
		wait_drained();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (expected_vwaps.size() != 0) begin
			$error("%0d expected VWAP items never arrived", expected_vwaps.size());
			error_count++;
		end

		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
